@@ rtl/core/xoro_pkg.sv @@
// Shared constants, types and helpers of the xoroshiro sampler.
`default_nettype none

package xoro_pkg;

	// Field and state widths
	localparam int unsigned REQ_W     = 3;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned SHORT_W   = 16;
	localparam int unsigned STATE_W   = 64;
	localparam int unsigned BIN_AW    = 16;
	localparam int unsigned BIN_DEPTH = 65536;
	localparam int unsigned BIN_W     = 8;
	localparam int unsigned CFG_IDX_W = 1;

	// Generator state after reset
	localparam logic [STATE_W-1:0] SEED_A_RESET = 64'd1;
	localparam logic [STATE_W-1:0] SEED_B_RESET = 64'd2;

	// Scrambler and state update rotations and shifts
	localparam int unsigned SCR_MUL5_SHIFT = 2;  // a * 5 = a + (a << 2)
	localparam int unsigned SCR_ROT        = 7;
	localparam int unsigned SCR_MUL9_SHIFT = 3;  // r * 9 = r + (r << 3)
	localparam int unsigned NEXT_ROT_A     = 24;
	localparam int unsigned NEXT_SHIFT     = 16;
	localparam int unsigned NEXT_ROT_B     = 37;

	typedef enum logic [REQ_W-1:0] {
		REQ_RAW      = 3'd0,
		REQ_SHORT    = 3'd1,
		REQ_EVENT    = 3'd2,
		REQ_SAMPLE   = 3'd3,
		REQ_WR_BIN   = 3'd4,
		REQ_WR_VALUE = 3'd5,
		REQ_RESEED   = 3'd6,
		REQ_NOP      = 3'd7
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SEED_A = 1'b0,
		CFG_SEED_B = 1'b1
	} cfg_reg_t;

	// Generator command for the cycle of a transfer
	typedef struct packed {
		logic advance;
		logic reseed;
	} gen_cmd_t;

	// Item held in the first stage
	typedef struct packed {
		req_t              req;
		logic [BIN_AW-1:0] addr;
		logic [BIN_W-1:0]  bin;
		logic [WORD_W-1:0] vword;
		logic [WORD_W-1:0] thresh;
		logic [WORD_W-1:0] rot;
	} s1_item_t;

	// Item held in the bin lookup stage
	typedef struct packed {
		req_t              req;
		logic [BIN_AW-1:0] addr;
		logic [WORD_W-1:0] vword;
		logic [WORD_W-1:0] word;
		logic              hit;
	} s2_item_t;

	// Result fields
	typedef struct packed {
		logic [WORD_W-1:0] random_word;
		logic              event_hit;
		logic [WORD_W-1:0] sample_value;
	} rsp_item_t;

	function automatic logic [STATE_W-1:0] rotl64(input logic [STATE_W-1:0] x,
		input int unsigned k);
		return (x << k) | (x >> (STATE_W - k));
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/xoro_req_if.sv @@
// Request channel: valid/ready handshake with the request fields.
`default_nettype none

interface xoro_req_if;
	import xoro_pkg::*;

	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [BIN_AW-1:0]   table_address;
	logic [BIN_W-1:0]    bin_number;
	logic [WORD_W-1:0]   value_word;
	logic [WORD_W-1:0]   event_threshold;

	modport source (output valid, req_type, table_address, bin_number, value_word,
		event_threshold, input ready);
	modport sink (input valid, req_type, table_address, bin_number, value_word,
		event_threshold, output ready);
endinterface

`default_nettype wire

@@ rtl/core/xoro_rsp_if.sv @@
// Result channel: valid/ready handshake with the result fields.
`default_nettype none

interface xoro_rsp_if;
	import xoro_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] random_word;
	logic              event_hit;
	logic [WORD_W-1:0] sample_value;

	modport source (output valid, random_word, event_hit, sample_value, input ready);
	modport sink (input valid, random_word, event_hit, sample_value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/xoro_gen.sv @@
// Generator state, seed registers and scrambler front end.
`default_nettype none

module xoro_gen (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [xoro_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [xoro_pkg::STATE_W-1:0]     cfg_data,
	input  xoro_pkg::gen_cmd_t               cmd,
	output logic [xoro_pkg::WORD_W-1:0]      rot_word
);
	import xoro_pkg::*;

	logic [STATE_W-1:0] seed_a_q;
	logic [STATE_W-1:0] seed_b_q;
	logic [STATE_W-1:0] gen_a_q;
	logic [STATE_W-1:0] gen_b_q;
	logic [STATE_W-1:0] a_times5;
	logic [STATE_W-1:0] a_scr;
	logic [STATE_W-1:0] b_mix;
	logic [STATE_W-1:0] a_next;
	logic [STATE_W-1:0] b_next;

	// Take seed writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_a_q <= SEED_A_RESET;
			seed_b_q <= SEED_B_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_SEED_A: seed_a_q <= cfg_data;
				CFG_SEED_B: seed_b_q <= cfg_data;
			endcase
		end
	end

	// Scramble the current word a; only the low word is kept
	always_comb begin
		a_times5 = gen_a_q + (gen_a_q << SCR_MUL5_SHIFT);
		a_scr    = rotl64(a_times5, SCR_ROT);
		rot_word = a_scr[WORD_W-1:0];
	end

	// Work out the next state
	always_comb begin
		b_mix  = gen_b_q ^ gen_a_q;
		a_next = rotl64(gen_a_q, NEXT_ROT_A) ^ b_mix ^ (b_mix << NEXT_SHIFT);
		b_next = rotl64(b_mix, NEXT_ROT_B);
	end

	// Reseed or advance on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_a_q <= SEED_A_RESET;
			gen_b_q <= SEED_B_RESET;
		end else if (cmd.reseed) begin
			gen_a_q <= seed_a_q;
			gen_b_q <= seed_b_q;
		end else if (cmd.advance) begin
			gen_a_q <= a_next;
			gen_b_q <= b_next;
		end
	end

`ifndef SYNTHESIS
	a_reseed_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.reseed |=> (gen_a_q == $past(seed_a_q)) && (gen_b_q == $past(seed_b_q)))
		else $error("generator state differs from seeds after reseed");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd.reseed && !cmd.advance) |=> $stable(gen_a_q) && $stable(gen_b_q))
		else $error("generator state moved without a draw or reseed");
`endif

endmodule

`default_nettype wire

@@ rtl/core/xoro_bin_stage.sv @@
// Scrambler finish, event compare and bin table lookup stage.
`default_nettype none

module xoro_bin_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_in,
	input  xoro_pkg::s1_item_t            item_in,
	output logic                          valid_s2,
	output xoro_pkg::s2_item_t            item_s2,
	output logic [xoro_pkg::BIN_W-1:0]    bin_rd_s2
);
	import xoro_pkg::*;

	logic [BIN_W-1:0]  bin_mem [BIN_DEPTH];
	logic [WORD_W-1:0] word;
	logic              hit;

	// Finish the scrambler (times nine) and test the threshold
	always_comb begin
		word = item_in.rot + (item_in.rot << SCR_MUL9_SHIFT);
		hit  = (word < item_in.thresh);
	end

	// Advance the stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_in;
		end
	end

	// Advance the stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			item_s2.req   <= item_in.req;
			item_s2.addr  <= item_in.addr;
			item_s2.vword <= item_in.vword;
			item_s2.word  <= word;
			item_s2.hit   <= hit;
		end
	end

	// Bin table: write a bin entry, and read at the short draw
	always_ff @(posedge clk) begin
		if (en) begin
			if (valid_in && (item_in.req == REQ_WR_BIN)) begin
				bin_mem[item_in.addr] <= item_in.bin;
			end
			bin_rd_s2 <= bin_mem[word[WORD_W-1:SHORT_W]];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/xoro_value_stage.sv @@
// Value table lookup and result register stage.
`default_nettype none

module xoro_value_stage #(
	parameter int unsigned VALUE_COUNT = 256,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_in,
	input  xoro_pkg::s2_item_t            item_in,
	input  logic [xoro_pkg::BIN_W-1:0]    bin_rd,
	output logic                          valid_s3,
	output xoro_pkg::rsp_item_t           rsp_item
);
	import xoro_pkg::*;

	localparam int unsigned VIDX_W = $clog2(VALUE_COUNT);

	logic [VALUE_WIDTH-1:0] val_mem [VALUE_COUNT];
	logic [VALUE_WIDTH-1:0] val_rd_s3;
	logic [WORD_W-1:0]      word_s3;
	logic                   hit_s3;
	logic                   take_s3;
	logic                   wr_ok;
	logic                   in_range;
	logic [WORD_W-1:0]      word_fmt;

	// Decode the value write and the bin range check
	always_comb begin
		wr_ok    = valid_in && (item_in.req == REQ_WR_VALUE) &&
			(32'(item_in.addr) < VALUE_COUNT);
		in_range = (32'(bin_rd) < VALUE_COUNT);
	end

	// Shape the draw for raw and short requests
	always_comb begin
		case (item_in.req)
			REQ_RAW:   word_fmt = item_in.word;
			REQ_SHORT: word_fmt = WORD_W'(item_in.word[WORD_W-1:SHORT_W]);
			default:   word_fmt = '0;
		endcase
	end

	// Advance the stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_in;
		end
	end

	// Advance the result payload
	always_ff @(posedge clk) begin
		if (en) begin
			word_s3 <= word_fmt;
			hit_s3  <= (item_in.req == REQ_EVENT) && item_in.hit;
			take_s3 <= (item_in.req == REQ_SAMPLE) && in_range;
		end
	end

	// Value table: write a value word, read at the bin just fetched
	always_ff @(posedge clk) begin
		if (en) begin
			if (wr_ok) begin
				val_mem[VIDX_W'(item_in.addr)] <= VALUE_WIDTH'(item_in.vword);
			end
			val_rd_s3 <= val_mem[VIDX_W'(bin_rd)];
		end
	end

	// Drive the result fields
	always_comb begin
		rsp_item.random_word  = word_s3;
		rsp_item.event_hit    = hit_s3;
		rsp_item.sample_value = take_s3 ? WORD_W'(val_rd_s3) : '0;
	end

endmodule

`default_nettype wire

@@ rtl/core/xoroshiro_sampler.sv @@
// Top level of the xoroshiro128** sampler: handshake, first stage and pipeline.
//
// Usage: requests arrive on the req channel (valid/ready); each transfer gives
// exactly one result on the rsp channel, in request order. Draw, event test and
// sample requests advance the generator; reseed loads it from the seed words;
// table writes and the spare code leave it; all three return all-zero fields.
// Seed registers are written on the cfg port (cfg_we, cfg_index, cfg_data);
// the user must do so only while the block is idle; it does not enforce this.
// Each request passes the first stage, bin lookup and value stage registers
// before rsp.valid rises. Throughput: one request per cycle while rsp.ready
// is high, set by the three-stage pipeline in which the bin table and the
// value table are each read once through a synchronous memory port.
// Stall: every stage moves up when the one after it is empty or moving, so
// gaps close up; req.ready falls only when all three stages hold items and
// the receiver holds rsp.ready low.
// Reset: generator and seed words return to 1 and 2, the pipeline empties;
// the table contents are undefined until written and are not cleared.
`default_nettype none

module xoroshiro_sampler #(
	parameter int unsigned VALUE_COUNT = 256,
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	xoro_req_if.sink                       req,
	xoro_rsp_if.source                     rsp,
	input  logic                           cfg_we,
	input  logic [xoro_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [xoro_pkg::STATE_W-1:0]   cfg_data
);
	import xoro_pkg::*;

	logic              en1;
	logic              en2;
	logic              en3;
	logic              accept;
	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	s1_item_t          item_s1;
	s2_item_t          item_s2;
	logic [BIN_W-1:0]  bin_rd_s2;
	logic [WORD_W-1:0] rot_word;
	gen_cmd_t          cmd;
	rsp_item_t         rsp_item;

	// Stage enables: move up when the next stage is empty or moving
	always_comb begin
		en3    = !valid_s3 || rsp.ready;
		en2    = !valid_s2 || en3;
		en1    = !valid_s1 || en2;
		accept = req.valid && en1;
	end

	assign req.ready = en1;

	// Decode the generator command for a transfer
	always_comb begin
		cmd = '0;
		if (accept) begin
			unique case (req_t'(req.req_type)) inside
				REQ_RAW, REQ_SHORT, REQ_EVENT, REQ_SAMPLE: cmd.advance = 1'b1;
				REQ_RESEED:                                cmd.reseed  = 1'b1;
				default:                                   cmd = '0;
			endcase
		end
	end

	xoro_gen u_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.rot_word (rot_word)
	);

	// First stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= req.valid;
		end
	end

	// First stage payload: request fields and the scrambled word
	always_ff @(posedge clk) begin
		if (en1) begin
			item_s1.req    <= req_t'(req.req_type);
			item_s1.addr   <= req.table_address;
			item_s1.bin    <= req.bin_number;
			item_s1.vword  <= req.value_word;
			item_s1.thresh <= req.event_threshold;
			item_s1.rot    <= rot_word;
		end
	end

	xoro_bin_stage u_bin_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en2),
		.valid_in (valid_s1),
		.item_in  (item_s1),
		.valid_s2 (valid_s2),
		.item_s2  (item_s2),
		.bin_rd_s2(bin_rd_s2)
	);

	xoro_value_stage #(
		.VALUE_COUNT(VALUE_COUNT),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_value_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en3),
		.valid_in(valid_s2),
		.item_in (item_s2),
		.bin_rd  (bin_rd_s2),
		.valid_s3(valid_s3),
		.rsp_item(rsp_item)
	);

	// Drive the result channel
	always_comb begin
		rsp.valid        = valid_s3;
		rsp.random_word  = rsp_item.random_word;
		rsp.event_hit    = rsp_item.event_hit;
		rsp.sample_value = rsp_item.sample_value;
	end

`ifndef SYNTHESIS
	a_transfer_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> valid_s1)
		else $error("accepted request did not enter the first stage");

	a_hit_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.event_hit) |-> (rsp.random_word == '0) && (rsp.sample_value == '0))
		else $error("event result carries a draw or sample value");

	a_sample_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.sample_value != '0)) |-> (rsp.random_word == '0) && !rsp.event_hit)
		else $error("sample result carries a draw or event flag");
`endif

endmodule

`default_nettype wire
